FILE: hw/rtl/bqsf_pkg.sv
// Shared constants, payload types, controller types and helpers for the quota sample filter.
`default_nettype none

package bqsf_pkg;

	localparam int MAX_PT_BINS  = 32;
	localparam int MAX_ETA_BINS = 32;
	localparam int NUM_CLASSES  = 4;

	localparam int PT_BIN_W  = $clog2(MAX_PT_BINS);
	localparam int ETA_BIN_W = $clog2(MAX_ETA_BINS);
	localparam int CLASS_W   = $clog2(NUM_CLASSES);
	localparam int CELL_ADDR_W = CLASS_W + PT_BIN_W + ETA_BIN_W;
	localparam int CELL_DEPTH  = 1 << CELL_ADDR_W;

	localparam int VALUE_W    = 16;
	localparam int COUNT_W    = 16;
	localparam int BINCNT_W   = 6;
	localparam int PARITY_W   = 2;
	localparam int CLASS_IN_W = 3;
	localparam int REASON_W   = 3;
	localparam int TOTAL_W    = 26;
	localparam int CTR_W      = 11;
	localparam int CFG_IDX_W  = 3;

	localparam logic [TOTAL_W-1:0] TOTAL_MAX = {TOTAL_W{1'b1}};
	localparam logic [CTR_W-1:0]   CTR_MAX   = {CTR_W{1'b1}};

	localparam int DIV_W     = 16;
	localparam int DIV_STEPS = DIV_W;
	localparam int STEP_W    = $clog2(DIV_STEPS);

	typedef enum logic [CFG_IDX_W-1:0] {
		REG_PT_ORIGIN      = 3'd0,
		REG_PT_BIN_WIDTH   = 3'd1,
		REG_PT_BIN_COUNT   = 3'd2,
		REG_ETA_ORIGIN     = 3'd3,
		REG_ETA_BIN_WIDTH  = 3'd4,
		REG_ETA_BIN_COUNT  = 3'd5,
		REG_TARGET_PER_BIN = 3'd6,
		REG_PARITY_MODE    = 3'd7
	} cfg_index_t;

	typedef enum logic [REASON_W-1:0] {
		REASON_ACCEPTED = 3'd0,
		REASON_PARITY   = 3'd1,
		REASON_UNMAPPED = 3'd2,
		REASON_RANGE    = 3'd3,
		REASON_FULL     = 3'd4,
		REASON_DONE     = 3'd5
	} reason_t;

	typedef struct packed {
		logic [VALUE_W-1:0]        pt_value;
		logic signed [VALUE_W-1:0] eta_value;
		logic                      event_odd;
		logic [CLASS_IN_W-1:0]     class_index;
	} item_t;

	typedef struct packed {
		logic                  accepted;
		logic [REASON_W-1:0]   reject_reason;
		logic [PT_BIN_W-1:0]   pt_bin;
		logic [ETA_BIN_W-1:0]  eta_bin;
		logic [COUNT_W-1:0]    bin_fill;
		logic [TOTAL_W-1:0]    class_accepted_total;
		logic                  class_complete;
		logic                  all_classes_done;
	} result_t;

	typedef enum logic [2:0] {
		ST_CLEAR,
		ST_IDLE,
		ST_CHECK,
		ST_DIV_PT,
		ST_DIV_ETA,
		ST_LOCATE,
		ST_UPDATE,
		ST_RESULT
	} state_t;

	typedef struct packed {
		logic clear_en;
		logic load_item;
		logic check;
		logic div_start;
		logic div_sel_eta;
		logic capture_pt;
		logic capture_eta;
		logic mem_read;
		logic update;
		logic load_result;
	} ctrl_cmd_t;

	typedef struct packed {
		logic clear_last;
		logic early_reject;
		logic div_done;
		logic out_of_range;
	} dp_status_t;

	function automatic logic [BINCNT_W-1:0] clamp_bins(input logic [BINCNT_W-1:0] raw,
			input logic [BINCNT_W-1:0] limit);
		logic [BINCNT_W-1:0] n;
		n = (raw == '0) ? BINCNT_W'(1) : raw;
		return (n > limit) ? limit : n;
	endfunction

	function automatic logic [VALUE_W-1:0] at_least_one(input logic [VALUE_W-1:0] v);
		return (v == '0) ? VALUE_W'(1) : v;
	endfunction

endpackage

`default_nettype wire

FILE: hw/rtl/bqsf_ram.sv
// Generic single-write, single-read RAM with registered read data.
`default_nettype none

module bqsf_ram #(
	parameter int WIDTH = 16,
	parameter int DEPTH = 4096
) (
	input  wire logic                     clk,
	input  wire logic                     we,
	input  wire logic [$clog2(DEPTH)-1:0] waddr,
	input  wire logic [WIDTH-1:0]         wdata,
	input  wire logic                     re,
	input  wire logic [$clog2(DEPTH)-1:0] raddr,
	output logic      [WIDTH-1:0]         rdata
);

	logic [WIDTH-1:0] mem [DEPTH];

	always_ff @(posedge clk) begin
		if (we) begin
			mem[waddr] <= wdata;
		end
		if (re) begin
			rdata <= mem[raddr];
		end
	end

endmodule

`default_nettype wire

FILE: hw/rtl/bqsf_div.sv
// Restoring divider that produces one quotient bit per cycle.
`default_nettype none

module bqsf_div (
	input  wire logic                        clk,
	input  wire logic                        arst_n,
	input  wire logic                        start,
	input  wire logic [bqsf_pkg::DIV_W-1:0]  dividend,
	input  wire logic [bqsf_pkg::DIV_W-1:0]  divisor,
	output logic      [bqsf_pkg::DIV_W-1:0]  quotient,
	output logic                             done
);

	logic                             active_q;
	logic [bqsf_pkg::STEP_W-1:0]      step_q;
	logic                             done_q;
	logic [bqsf_pkg::DIV_W-1:0]       rem_q;
	logic [bqsf_pkg::DIV_W-1:0]       quo_q;
	logic [bqsf_pkg::DIV_W-1:0]       div_q;
	logic [bqsf_pkg::DIV_W:0]         shifted;
	logic [bqsf_pkg::DIV_W:0]         trial;
	logic                             fits;

	always_comb begin
		shifted = {rem_q, quo_q[bqsf_pkg::DIV_W-1]};
		fits    = shifted >= {1'b0, div_q};
		trial   = shifted - {1'b0, div_q};
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			active_q <= 1'b0;
			step_q   <= '0;
			done_q   <= 1'b0;
		end else begin
			done_q <= 1'b0;
			if (start) begin
				active_q <= 1'b1;
				step_q   <= '0;
			end else if (active_q) begin
				step_q <= step_q + bqsf_pkg::STEP_W'(1);
				if (step_q == bqsf_pkg::STEP_W'(bqsf_pkg::DIV_STEPS - 1)) begin
					active_q <= 1'b0;
					done_q   <= 1'b1;
				end
			end
		end
	end

	always_ff @(posedge clk) begin
		if (start) begin
			rem_q <= '0;
			quo_q <= dividend;
			div_q <= divisor;
		end else if (active_q) begin
			rem_q <= fits ? trial[bqsf_pkg::DIV_W-1:0] : shifted[bqsf_pkg::DIV_W-1:0];
			quo_q <= {quo_q[bqsf_pkg::DIV_W-2:0], fits};
		end
	end

	assign quotient = quo_q;
	assign done     = done_q;

endmodule

`default_nettype wire

FILE: hw/rtl/bqsf_dp.sv
// Datapath: configuration registers, bin location, cell count store and class counters.
`default_nettype none

module bqsf_dp (
	input  wire logic                              clk,
	input  wire logic                              arst_n,
	input  wire bqsf_pkg::ctrl_cmd_t               cmd,
	output bqsf_pkg::dp_status_t                   status,
	input  wire bqsf_pkg::item_t                   item,
	input  wire logic                              cfg_valid,
	input  wire logic [bqsf_pkg::CFG_IDX_W-1:0]    cfg_index,
	input  wire logic [bqsf_pkg::VALUE_W-1:0]      cfg_data,
	output bqsf_pkg::result_t                      result,
	output logic                                   done
);

	logic [bqsf_pkg::VALUE_W-1:0]   pt_origin_q;
	logic [bqsf_pkg::VALUE_W-1:0]   pt_bin_width_q;
	logic [bqsf_pkg::BINCNT_W-1:0]  pt_bin_count_q;
	logic [bqsf_pkg::VALUE_W-1:0]   eta_origin_q;
	logic [bqsf_pkg::VALUE_W-1:0]   eta_bin_width_q;
	logic [bqsf_pkg::BINCNT_W-1:0]  eta_bin_count_q;
	logic [bqsf_pkg::VALUE_W-1:0]   target_q;
	logic [bqsf_pkg::PARITY_W-1:0]  parity_q;

	bqsf_pkg::item_t                item_q;
	bqsf_pkg::reason_t              early_q;
	bqsf_pkg::reason_t              early_reason;
	bqsf_pkg::reason_t              reason;

	logic [bqsf_pkg::TOTAL_W-1:0]   totals_q   [bqsf_pkg::NUM_CLASSES];
	logic [bqsf_pkg::CTR_W-1:0]     full_q     [bqsf_pkg::NUM_CLASSES];
	logic [bqsf_pkg::CTR_W-1:0]     nonempty_q [bqsf_pkg::NUM_CLASSES];
	logic [bqsf_pkg::NUM_CLASSES-1:0] class_done;

	logic [bqsf_pkg::CELL_ADDR_W-1:0] clear_addr_q;
	logic                             pt_ok_q;
	logic                             eta_ok_q;
	logic [bqsf_pkg::PT_BIN_W-1:0]    pt_bin_q;
	logic [bqsf_pkg::ETA_BIN_W-1:0]   eta_bin_q;
	logic                             bin_full_q;
	logic [bqsf_pkg::COUNT_W-1:0]     fill_q;
	bqsf_pkg::result_t                result_q;
	logic                             done_q;

	logic [bqsf_pkg::BINCNT_W-1:0]    pt_n;
	logic [bqsf_pkg::BINCNT_W-1:0]    eta_n;
	logic [bqsf_pkg::CTR_W-1:0]       cells;
	logic                             all_done;
	logic                             mapped;
	logic [bqsf_pkg::CLASS_W-1:0]     cls;
	logic                             parity_rej;
	logic [bqsf_pkg::VALUE_W:0]       pt_diff;
	logic [bqsf_pkg::VALUE_W:0]       eta_diff;
	logic [bqsf_pkg::DIV_W-1:0]       div_dividend;
	logic [bqsf_pkg::DIV_W-1:0]       div_divisor;
	logic [bqsf_pkg::DIV_W-1:0]       quotient;
	logic                             div_done;
	logic                             q_in_pt;
	logic                             q_in_eta;

	logic [bqsf_pkg::CELL_ADDR_W-1:0] cell_addr;
	logic [bqsf_pkg::COUNT_W-1:0]     cell_count;
	logic [bqsf_pkg::COUNT_W-1:0]     cell_next;
	logic [bqsf_pkg::COUNT_W-1:0]     target;
	logic                             cell_full;
	logic                             mem_we;
	logic [bqsf_pkg::CELL_ADDR_W-1:0] mem_waddr;
	logic [bqsf_pkg::COUNT_W-1:0]     mem_wdata;
	logic                             show_bins;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			pt_origin_q     <= '0;
			pt_bin_width_q  <= bqsf_pkg::VALUE_W'(64);
			pt_bin_count_q  <= bqsf_pkg::BINCNT_W'(1);
			eta_origin_q    <= '0;
			eta_bin_width_q <= bqsf_pkg::VALUE_W'(4096);
			eta_bin_count_q <= bqsf_pkg::BINCNT_W'(1);
			target_q        <= bqsf_pkg::VALUE_W'(1);
			parity_q        <= '0;
		end else if (cfg_valid) begin
			unique case (bqsf_pkg::cfg_index_t'(cfg_index))
				bqsf_pkg::REG_PT_ORIGIN:      pt_origin_q     <= cfg_data;
				bqsf_pkg::REG_PT_BIN_WIDTH:   pt_bin_width_q  <= cfg_data;
				bqsf_pkg::REG_PT_BIN_COUNT:   pt_bin_count_q  <= cfg_data[bqsf_pkg::BINCNT_W-1:0];
				bqsf_pkg::REG_ETA_ORIGIN:     eta_origin_q    <= cfg_data;
				bqsf_pkg::REG_ETA_BIN_WIDTH:  eta_bin_width_q <= cfg_data;
				bqsf_pkg::REG_ETA_BIN_COUNT:  eta_bin_count_q <= cfg_data[bqsf_pkg::BINCNT_W-1:0];
				bqsf_pkg::REG_TARGET_PER_BIN: target_q        <= cfg_data;
				bqsf_pkg::REG_PARITY_MODE:    parity_q        <= cfg_data[bqsf_pkg::PARITY_W-1:0];
				default: ;
			endcase
		end
	end

	always_comb begin
		pt_n  = bqsf_pkg::clamp_bins(pt_bin_count_q, bqsf_pkg::BINCNT_W'(bqsf_pkg::MAX_PT_BINS));
		eta_n = bqsf_pkg::clamp_bins(eta_bin_count_q, bqsf_pkg::BINCNT_W'(bqsf_pkg::MAX_ETA_BINS));
		cells = bqsf_pkg::CTR_W'(pt_n) * bqsf_pkg::CTR_W'(eta_n);
		for (int c = 0; c < bqsf_pkg::NUM_CLASSES; c++) begin
			class_done[c] = full_q[c] >= cells;
		end
		all_done = &class_done;

		mapped     = item_q.class_index < bqsf_pkg::CLASS_IN_W'(bqsf_pkg::NUM_CLASSES);
		cls        = item_q.class_index[bqsf_pkg::CLASS_W-1:0];
		parity_rej = (parity_q[0] && !item_q.event_odd) || (parity_q[1] && item_q.event_odd);

		if (all_done) begin
			early_reason = bqsf_pkg::REASON_DONE;
		end else if (parity_rej) begin
			early_reason = bqsf_pkg::REASON_PARITY;
		end else if (!mapped) begin
			early_reason = bqsf_pkg::REASON_UNMAPPED;
		end else begin
			early_reason = bqsf_pkg::REASON_ACCEPTED;
		end

		pt_diff  = {1'b0, item_q.pt_value} - {1'b0, pt_origin_q};
		eta_diff = {item_q.eta_value[bqsf_pkg::VALUE_W-1], item_q.eta_value}
			- {eta_origin_q[bqsf_pkg::VALUE_W-1], eta_origin_q};

		div_dividend = cmd.div_sel_eta ? eta_diff[bqsf_pkg::DIV_W-1:0] : pt_diff[bqsf_pkg::DIV_W-1:0];
		div_divisor  = cmd.div_sel_eta ? bqsf_pkg::at_least_one(eta_bin_width_q)
			: bqsf_pkg::at_least_one(pt_bin_width_q);

		q_in_pt  = !pt_diff[bqsf_pkg::VALUE_W] && (quotient < bqsf_pkg::DIV_W'(pt_n));
		q_in_eta = !eta_diff[bqsf_pkg::VALUE_W] && (quotient < bqsf_pkg::DIV_W'(eta_n));
	end

	bqsf_div u_div (
		.clk      (clk),
		.arst_n   (arst_n),
		.start    (cmd.div_start),
		.dividend (div_dividend),
		.divisor  (div_divisor),
		.quotient (quotient),
		.done     (div_done)
	);

	always_comb begin
		cell_addr  = {cls, pt_bin_q, eta_bin_q};
		target     = bqsf_pkg::at_least_one(target_q);
		cell_full  = cell_count >= target;
		cell_next  = cell_count + bqsf_pkg::COUNT_W'(1);
		mem_we     = cmd.clear_en || (cmd.update && !cell_full);
		mem_waddr  = cmd.clear_en ? clear_addr_q : cell_addr;
		mem_wdata  = cmd.clear_en ? '0 : cell_next;
	end

	bqsf_ram #(
		.WIDTH (bqsf_pkg::COUNT_W),
		.DEPTH (bqsf_pkg::CELL_DEPTH)
	) u_cells (
		.clk   (clk),
		.we    (mem_we),
		.waddr (mem_waddr),
		.wdata (mem_wdata),
		.re    (cmd.mem_read),
		.raddr (cell_addr),
		.rdata (cell_count)
	);

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			clear_addr_q <= '0;
			done_q       <= 1'b0;
			for (int c = 0; c < bqsf_pkg::NUM_CLASSES; c++) begin
				totals_q[c]   <= '0;
				full_q[c]     <= '0;
				nonempty_q[c] <= '0;
			end
		end else begin
			done_q <= cmd.load_result;
			if (cmd.clear_en) begin
				clear_addr_q <= clear_addr_q + bqsf_pkg::CELL_ADDR_W'(1);
			end
			if (cmd.update && !cell_full) begin
				if (totals_q[cls] != bqsf_pkg::TOTAL_MAX) begin
					totals_q[cls] <= totals_q[cls] + bqsf_pkg::TOTAL_W'(1);
				end
				if ((cell_next == bqsf_pkg::COUNT_W'(1)) && (nonempty_q[cls] != bqsf_pkg::CTR_MAX)) begin
					nonempty_q[cls] <= nonempty_q[cls] + bqsf_pkg::CTR_W'(1);
				end
				if ((cell_next == target) && (full_q[cls] != bqsf_pkg::CTR_MAX)) begin
					full_q[cls] <= full_q[cls] + bqsf_pkg::CTR_W'(1);
				end
			end
		end
	end

	always_ff @(posedge clk) begin
		if (cmd.load_item) begin
			item_q <= item;
		end
		if (cmd.check) begin
			early_q <= early_reason;
		end
		if (cmd.capture_pt) begin
			pt_ok_q  <= q_in_pt;
			pt_bin_q <= quotient[bqsf_pkg::PT_BIN_W-1:0];
		end
		if (cmd.capture_eta) begin
			eta_ok_q  <= q_in_eta;
			eta_bin_q <= quotient[bqsf_pkg::ETA_BIN_W-1:0];
		end
		if (cmd.update) begin
			bin_full_q <= cell_full;
			fill_q     <= cell_full ? cell_count : cell_next;
		end
		if (cmd.load_result) begin
			result_q.accepted      <= reason == bqsf_pkg::REASON_ACCEPTED;
			result_q.reject_reason <= reason;
			result_q.pt_bin        <= show_bins ? pt_bin_q : '0;
			result_q.eta_bin       <= show_bins ? eta_bin_q : '0;
			result_q.bin_fill      <= show_bins ? fill_q : '0;
			result_q.class_accepted_total <= mapped ? totals_q[cls] : '0;
			result_q.class_complete <= mapped && class_done[cls];
			result_q.all_classes_done <= all_done;
		end
	end

	always_comb begin
		if (early_q != bqsf_pkg::REASON_ACCEPTED) begin
			reason = early_q;
		end else if (!pt_ok_q || !eta_ok_q) begin
			reason = bqsf_pkg::REASON_RANGE;
		end else if (bin_full_q) begin
			reason = bqsf_pkg::REASON_FULL;
		end else begin
			reason = bqsf_pkg::REASON_ACCEPTED;
		end
		show_bins = (reason == bqsf_pkg::REASON_ACCEPTED) || (reason == bqsf_pkg::REASON_FULL);
	end

	always_comb begin
		status.clear_last   = &clear_addr_q;
		status.early_reject = early_reason != bqsf_pkg::REASON_ACCEPTED;
		status.div_done     = div_done;
		status.out_of_range = !(pt_ok_q && eta_ok_q);
	end

	assign result = result_q;
	assign done   = done_q;

endmodule

`default_nettype wire

FILE: hw/rtl/bqsf_ctrl.sv
// Controller state machine that sequences clearing, bin location, cell update and reporting.
`default_nettype none

module bqsf_ctrl (
	input  wire logic                  clk,
	input  wire logic                  arst_n,
	input  wire logic                  start,
	input  wire bqsf_pkg::dp_status_t  status,
	output bqsf_pkg::ctrl_cmd_t        cmd,
	output logic                       busy
);

	bqsf_pkg::state_t state_q;
	bqsf_pkg::state_t state_d;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q <= bqsf_pkg::ST_CLEAR;
		end else begin
			state_q <= state_d;
		end
	end

	always_comb begin
		state_d = state_q;
		unique case (state_q)
			bqsf_pkg::ST_CLEAR: begin
				if (status.clear_last) begin
					state_d = bqsf_pkg::ST_IDLE;
				end
			end
			bqsf_pkg::ST_IDLE: begin
				if (start) begin
					state_d = bqsf_pkg::ST_CHECK;
				end
			end
			bqsf_pkg::ST_CHECK: begin
				state_d = status.early_reject ? bqsf_pkg::ST_RESULT : bqsf_pkg::ST_DIV_PT;
			end
			bqsf_pkg::ST_DIV_PT: begin
				if (status.div_done) begin
					state_d = bqsf_pkg::ST_DIV_ETA;
				end
			end
			bqsf_pkg::ST_DIV_ETA: begin
				if (status.div_done) begin
					state_d = bqsf_pkg::ST_LOCATE;
				end
			end
			bqsf_pkg::ST_LOCATE: begin
				state_d = status.out_of_range ? bqsf_pkg::ST_RESULT : bqsf_pkg::ST_UPDATE;
			end
			bqsf_pkg::ST_UPDATE: begin
				state_d = bqsf_pkg::ST_RESULT;
			end
			bqsf_pkg::ST_RESULT: begin
				state_d = bqsf_pkg::ST_IDLE;
			end
			default: begin
				state_d = bqsf_pkg::ST_IDLE;
			end
		endcase
	end

	always_comb begin
		cmd  = '0;
		busy = 1'b1;
		unique case (state_q)
			bqsf_pkg::ST_CLEAR: begin
				cmd.clear_en = 1'b1;
			end
			bqsf_pkg::ST_IDLE: begin
				busy          = 1'b0;
				cmd.load_item = start;
			end
			bqsf_pkg::ST_CHECK: begin
				cmd.check     = 1'b1;
				cmd.div_start = !status.early_reject;
			end
			bqsf_pkg::ST_DIV_PT: begin
				cmd.capture_pt  = status.div_done;
				cmd.div_start   = status.div_done;
				cmd.div_sel_eta = 1'b1;
			end
			bqsf_pkg::ST_DIV_ETA: begin
				cmd.div_sel_eta = 1'b1;
				cmd.capture_eta = status.div_done;
			end
			bqsf_pkg::ST_LOCATE: begin
				cmd.mem_read = !status.out_of_range;
			end
			bqsf_pkg::ST_UPDATE: begin
				cmd.update = 1'b1;
			end
			bqsf_pkg::ST_RESULT: begin
				cmd.load_result = 1'b1;
			end
			default: begin
				cmd = '0;
			end
		endcase
	end

endmodule

`default_nettype wire

FILE: hw/rtl/binned_quota_sample_filter.sv
// Top level of the binned quota sample filter: controller and datapath.
//
//   Channel   Handshake               Payload
//   -------   ---------------------   -------------------------------------------
//   item      start, busy             item (pt_value, eta_value, event_odd, class)
//   result    done (one-cycle strobe) result (reason, bins, fill, class totals)
//   config    cfg_valid, cfg_ready    cfg_index, cfg_data
//
// An item that is rejected by the all-done, parity or class checks goes from the check state
// straight to the result state; any other item runs the shared one-bit-per-cycle divider for pt
// and then for eta, and one that is in range then reads and updates its cell before its result.
// The next item can transfer in the cycle of the done strobe.
// After reset the 4096 entries of the cell count memory are cleared one entry per cycle, with
// busy held high; configuration writes are taken throughout.
// The result is registered and shown for one cycle; the receiver cannot stall it.
`default_nettype none

module binned_quota_sample_filter (
	input  wire logic                             clk,
	input  wire logic                             arst_n,
	input  wire logic                             start,
	output logic                                  busy,
	input  wire bqsf_pkg::item_t                  item,
	output logic                                  done,
	output bqsf_pkg::result_t                     result,
	input  wire logic                             cfg_valid,
	output logic                                  cfg_ready,
	input  wire logic [bqsf_pkg::CFG_IDX_W-1:0]   cfg_index,
	input  wire logic [bqsf_pkg::VALUE_W-1:0]     cfg_data
);

	bqsf_pkg::ctrl_cmd_t  cmd;
	bqsf_pkg::dp_status_t status;

	assign cfg_ready = 1'b1;

	bqsf_ctrl u_ctrl (
		.clk    (clk),
		.arst_n (arst_n),
		.start  (start),
		.status (status),
		.cmd    (cmd),
		.busy   (busy)
	);

	bqsf_dp u_dp (
		.clk       (clk),
		.arst_n    (arst_n),
		.cmd       (cmd),
		.status    (status),
		.item      (item),
		.cfg_valid (cfg_valid && cfg_ready),
		.cfg_index (cfg_index),
		.cfg_data  (cfg_data),
		.result    (result),
		.done      (done)
	);

endmodule

`default_nettype wire

FILE: hw/rtl/bqsf_checker.sv
// Port-level checker for the quota sample filter and its bind to the top level.
`default_nettype none

module bqsf_checker (
	input wire logic               clk,
	input wire logic               arst_n,
	input wire logic               start,
	input wire logic               busy,
	input wire logic               done,
	input wire bqsf_pkg::result_t  result
);

	a_done_when_free: assert property (@(posedge clk) disable iff (!arst_n)
		done |-> !busy)
		else $error("result strobe while the block is busy");

	a_transfer_starts_work: assert property (@(posedge clk) disable iff (!arst_n)
		(start && !busy) |=> busy)
		else $error("accepted item did not make the block busy");

	a_accept_flag: assert property (@(posedge clk) disable iff (!arst_n)
		done |-> (result.accepted == (result.reject_reason == bqsf_pkg::REASON_ACCEPTED)))
		else $error("accepted flag disagrees with reject reason");

	a_accept_counts: assert property (@(posedge clk) disable iff (!arst_n)
		(done && result.accepted) |-> (result.bin_fill != '0 && result.class_accepted_total != '0))
		else $error("accepted item left an empty bin or class total");

	a_bins_zero: assert property (@(posedge clk) disable iff (!arst_n)
		(done && (result.reject_reason == bqsf_pkg::REASON_PARITY
			|| result.reject_reason == bqsf_pkg::REASON_UNMAPPED
			|| result.reject_reason == bqsf_pkg::REASON_RANGE
			|| result.reject_reason == bqsf_pkg::REASON_DONE))
		|-> (result.pt_bin == '0 && result.eta_bin == '0 && result.bin_fill == '0))
		else $error("bin fields not zero for an early rejection");

endmodule

bind binned_quota_sample_filter bqsf_checker u_bqsf_checker (
	.clk    (clk),
	.arst_n (arst_n),
	.start  (start),
	.busy   (busy),
	.done   (done),
	.result (result)
);

`default_nettype wire

FILE: tb/sv/bqsf_quota_checker.sv
// Checker for the binned quota sample filter: predicts each result from the accepted candidates and compares it.
module bqsf_quota_checker (
	input  wire logic                           clk,
	input  wire logic                           arst_n,
	input  wire logic                           start,
	input  wire logic                           busy,
	input  wire bqsf_pkg::item_t                item,
	input  wire logic                           done,
	input  wire bqsf_pkg::result_t              result,
	input  wire logic                           cfg_valid,
	input  wire logic                           cfg_ready,
	input  wire logic [bqsf_pkg::CFG_IDX_W-1:0] cfg_index,
	input  wire logic [bqsf_pkg::VALUE_W-1:0]   cfg_data,
	output int                                  mismatches,
	output int                                  pending
);
	timeunit 1ns;
	timeprecision 1ps;

	import bqsf_pkg::*;

	logic [15:0]        pt_origin_q;
	logic [15:0]        pt_width_q;
	logic [5:0]         pt_count_q;
	logic signed [15:0] eta_origin_q;
	logic [15:0]        eta_width_q;
	logic [5:0]         eta_count_q;
	logic [15:0]        target_q;
	logic [1:0]         parity_q;

	logic [COUNT_W-1:0] cell_count [MAX_PT_BINS*MAX_ETA_BINS*NUM_CLASSES];
	logic [TOTAL_W-1:0] class_total [NUM_CLASSES];
	logic [CTR_W-1:0]   full_cells [NUM_CLASSES];

	result_t pending_verdicts [$];

	function automatic int bins_in_use(input logic [5:0] n, input int limit);
		int v;
		v = (n == '0) ? 1 : int'(n);
		return (v > limit) ? limit : v;
	endfunction

	function automatic int nonzero(input logic [15:0] v);
		return (v == '0) ? 1 : int'(v);
	endfunction

	function automatic logic class_filled(input int c);
		return int'(full_cells[c]) >= bins_in_use(pt_count_q, MAX_PT_BINS) *
			bins_in_use(eta_count_q, MAX_ETA_BINS);
	endfunction

	function automatic logic all_classes_filled();
		for (int c = 0; c < NUM_CLASSES; c++) begin
			if (!class_filled(c))
				return 1'b0;
		end
		return 1'b1;
	endfunction

	task automatic classify_candidate(input item_t cand, output result_t verdict);
		int cls;
		int pt_diff;
		int eta_diff;
		int pt_bin_i;
		int eta_bin_i;
		int addr;
		int fill;
		int goal;
		logic mapped;
		logic in_range;
		reason_t why;
		cls = int'(cand.class_index);
		mapped = cls < NUM_CLASSES;
		goal = nonzero(target_q);
		pt_diff = int'(cand.pt_value) - int'(pt_origin_q);
		eta_diff = int'($signed(cand.eta_value)) - int'(eta_origin_q);
		pt_bin_i = 0;
		eta_bin_i = 0;
		fill = 0;
		if (all_classes_filled())
			why = REASON_DONE;
		else if ((parity_q[0] && !cand.event_odd) || (parity_q[1] && cand.event_odd))
			why = REASON_PARITY;
		else if (!mapped)
			why = REASON_UNMAPPED;
		else begin
			in_range = (pt_diff >= 0) && (eta_diff >= 0);
			if (in_range) begin
				pt_bin_i = pt_diff / nonzero(pt_width_q);
				eta_bin_i = eta_diff / nonzero(eta_width_q);
				in_range = (pt_bin_i < bins_in_use(pt_count_q, MAX_PT_BINS)) &&
					(eta_bin_i < bins_in_use(eta_count_q, MAX_ETA_BINS));
			end
			if (!in_range) begin
				why = REASON_RANGE;
				pt_bin_i = 0;
				eta_bin_i = 0;
			end else begin
				addr = (cls * MAX_PT_BINS + pt_bin_i) * MAX_ETA_BINS + eta_bin_i;
				fill = int'(cell_count[addr]);
				if (fill >= goal) begin
					why = REASON_FULL;
				end else begin
					why = REASON_ACCEPTED;
					fill++;
					cell_count[addr] = COUNT_W'(fill);
					if (class_total[cls] != TOTAL_MAX)
						class_total[cls]++;
					if (fill == goal && full_cells[cls] != CTR_MAX)
						full_cells[cls]++;
				end
			end
		end
		verdict.accepted = (why == REASON_ACCEPTED);
		verdict.reject_reason = why;
		verdict.pt_bin = pt_bin_i[PT_BIN_W-1:0];
		verdict.eta_bin = eta_bin_i[ETA_BIN_W-1:0];
		verdict.bin_fill = fill[COUNT_W-1:0];
		verdict.class_accepted_total = mapped ? class_total[cls] : '0;
		verdict.class_complete = mapped && class_filled(cls);
		verdict.all_classes_done = all_classes_filled();
	endtask

	task automatic compare_field(input string field, input logic [31:0] want_v,
			input logic [31:0] got_v);
		if (got_v !== want_v) begin
			$display("%0t: %s expected %0h actual %0h", $time, field, want_v, got_v);
			mismatches++;
		end
	endtask

	always @(posedge clk or negedge arst_n) begin : watch
		result_t want;
		if (!arst_n) begin
			pt_origin_q = '0;
			pt_width_q = 16'd64;
			pt_count_q = 6'd1;
			eta_origin_q = '0;
			eta_width_q = 16'd4096;
			eta_count_q = 6'd1;
			target_q = 16'd1;
			parity_q = '0;
			foreach (cell_count[i])
				cell_count[i] = '0;
			foreach (class_total[c]) begin
				class_total[c] = '0;
				full_cells[c] = '0;
			end
			pending_verdicts.delete();
			mismatches = 0;
			pending = 0;
		end else begin
			if (done) begin
				if (pending_verdicts.size() == 0) begin
					$display("%0t: result expected none actual %0h", $time, result);
					mismatches++;
				end else begin
					want = pending_verdicts.pop_front();
					pending--;
					compare_field("accepted", want.accepted, result.accepted);
					compare_field("reject_reason", want.reject_reason, result.reject_reason);
					compare_field("pt_bin", want.pt_bin, result.pt_bin);
					compare_field("eta_bin", want.eta_bin, result.eta_bin);
					compare_field("bin_fill", want.bin_fill, result.bin_fill);
					compare_field("class_accepted_total", want.class_accepted_total,
						result.class_accepted_total);
					compare_field("class_complete", want.class_complete, result.class_complete);
					compare_field("all_classes_done", want.all_classes_done,
						result.all_classes_done);
				end
			end
			if (cfg_valid && cfg_ready) begin
				case (cfg_index_t'(cfg_index))
					REG_PT_ORIGIN:      pt_origin_q = cfg_data;
					REG_PT_BIN_WIDTH:   pt_width_q = cfg_data;
					REG_PT_BIN_COUNT:   pt_count_q = cfg_data[5:0];
					REG_ETA_ORIGIN:     eta_origin_q = cfg_data;
					REG_ETA_BIN_WIDTH:  eta_width_q = cfg_data;
					REG_ETA_BIN_COUNT:  eta_count_q = cfg_data[5:0];
					REG_TARGET_PER_BIN: target_q = cfg_data;
					REG_PARITY_MODE:    parity_q = cfg_data[1:0];
					default: ;
				endcase
			end
			if (start && !busy) begin
				classify_candidate(item, want);
				pending_verdicts = {pending_verdicts, want};
				pending++;
			end
		end
	end

endmodule

FILE: tb/sv/tb_binned_quota_sample_filter.sv
// Testbench top for the binned quota sample filter: clock, reset, candidate and register stimulus, verdict.
module tb_binned_quota_sample_filter;
	timeunit 1ns;
	timeprecision 1ps;

	import bqsf_pkg::*;

	localparam int ITEM_BUDGET = 1950;

	logic                 clk;
	logic                 arst_n;
	logic                 start;
	logic                 busy;
	item_t                item;
	logic                 done;
	result_t              result;
	logic                 cfg_valid;
	logic                 cfg_ready;
	logic [CFG_IDX_W-1:0] cfg_index;
	logic [VALUE_W-1:0]   cfg_data;
	int                   mismatches;
	int                   pending;
	logic                 quiet;
	logic                 last_all_done;
	int                   sent;

	binned_quota_sample_filter dut (
		.clk       (clk),
		.arst_n    (arst_n),
		.start     (start),
		.busy      (busy),
		.item      (item),
		.done      (done),
		.result    (result),
		.cfg_valid (cfg_valid),
		.cfg_ready (cfg_ready),
		.cfg_index (cfg_index),
		.cfg_data  (cfg_data)
	);

	bqsf_quota_checker quota_check (
		.clk        (clk),
		.arst_n     (arst_n),
		.start      (start),
		.busy       (busy),
		.item       (item),
		.done       (done),
		.result     (result),
		.cfg_valid  (cfg_valid),
		.cfg_ready  (cfg_ready),
		.cfg_index  (cfg_index),
		.cfg_data   (cfg_data),
		.mismatches (mismatches),
		.pending    (pending)
	);

	initial begin
		clk = 1'b0;
		forever #5 clk = ~clk;
	end

	initial begin
		#10ms;
		$display("[FAIL] regression broken");
		$finish;
	end

	always @(posedge clk or negedge arst_n) begin
		if (!arst_n)
			last_all_done <= 1'b0;
		else if (done)
			last_all_done <= result.all_classes_done;
	end

	function automatic item_t cand(input logic [15:0] pt, input logic [15:0] eta,
			input logic odd, input logic [2:0] cls);
		item_t c;
		c.pt_value = pt;
		c.eta_value = eta;
		c.event_odd = odd;
		c.class_index = cls;
		return c;
	endfunction

	function automatic int grid_bins(input logic [5:0] n);
		if (n == '0)
			return 1;
		return (n > 6'd32) ? 32 : int'(n);
	endfunction

	task automatic drive_candidate(input item_t it);
		if (!quiet && $urandom_range(99) < 12) begin
			start <= 1'b0;
			repeat ($urandom_range(1, 45)) @(negedge clk);
		end
		start <= 1'b1;
		item <= it;
		do @(posedge clk); while (busy);
		@(negedge clk);
		sent++;
	endtask

	task automatic write_reg(input cfg_index_t idx, input logic [15:0] value);
		if (!quiet && $urandom_range(99) < 12) begin
			cfg_valid <= 1'b0;
			repeat ($urandom_range(1, 6)) @(negedge clk);
		end
		cfg_valid <= 1'b1;
		cfg_index <= idx;
		cfg_data <= value;
		do @(posedge clk); while (!cfg_ready);
		@(negedge clk);
	endtask

	task automatic load_setup(input logic [15:0] po, input logic [15:0] pw, input logic [5:0] pn,
			input logic [15:0] eo, input logic [15:0] ew, input logic [5:0] en,
			input logic [15:0] tg, input logic [1:0] pm);
		write_reg(REG_PT_ORIGIN, po);
		write_reg(REG_PT_BIN_WIDTH, pw);
		write_reg(REG_PT_BIN_COUNT, {10'd0, pn});
		write_reg(REG_ETA_ORIGIN, eo);
		write_reg(REG_ETA_BIN_WIDTH, ew);
		write_reg(REG_ETA_BIN_COUNT, {10'd0, en});
		write_reg(REG_TARGET_PER_BIN, tg);
		write_reg(REG_PARITY_MODE, {14'd0, pm});
		cfg_valid <= 1'b0;
	endtask

	// The sender holds off until every outstanding result has been seen.
	task automatic settle();
		start <= 1'b0;
		while (pending != 0) @(negedge clk);
	endtask

	initial begin : stimulus
		item_t it;
		int span;
		int phase_len;
		int r;
		int pe;
		int ee;
		int pwe;
		int ewe;
		int eo_int;
		int pt_int;
		int eta_int;
		logic [15:0] po;
		logic [15:0] pw;
		logic [15:0] eo;
		logic [15:0] ew;
		logic [15:0] tg;
		logic [5:0] pn;
		logic [5:0] en;
		logic [1:0] pm;

		arst_n = 1'b0;
		start = 1'b0;
		item = '0;
		cfg_valid = 1'b0;
		cfg_index = '0;
		cfg_data = '0;
		quiet = 1'b0;
		sent = 0;
		repeat (12) @(posedge clk);
		@(negedge clk);
		arst_n <= 1'b1;

		// Register values as they come out of reset: one bin per axis, one entry per bin.
		drive_candidate(cand(16'd0, 16'd0, 1'b0, 3'd4));
		drive_candidate(cand(16'hFFFF, 16'h8000, 1'b1, 3'd7));
		drive_candidate(cand(16'd64, 16'd0, 1'b0, 3'd0));
		drive_candidate(cand(16'd0, 16'hFFFF, 1'b0, 3'd1));
		drive_candidate(cand(16'd0, 16'h7FFF, 1'b1, 3'd2));
		drive_candidate(cand(16'hFFFF, 16'd4096, 1'b0, 3'd3));
		drive_candidate(cand(16'd63, 16'd4095, 1'b1, 3'd0));
		drive_candidate(cand(16'd63, 16'd4095, 1'b1, 3'd0));
		drive_candidate(cand(16'd0, 16'd0, 1'b0, 3'd1));
		drive_candidate(cand(16'd32, 16'd2048, 1'b1, 3'd2));
		drive_candidate(cand(16'd1, 16'd1, 1'b0, 3'd3));
		drive_candidate(cand(16'd0, 16'd0, 1'b0, 3'd4));

		// Zero and oversized registers, parity filter rejecting everything.
		settle();
		load_setup(16'hFFFF, 16'hFFFF, 6'd63, 16'h8000, 16'd0, 6'd0, 16'd0, 2'd3);
		drive_candidate(cand(16'hFFFF, 16'h8000, 1'b0, 3'd0));
		drive_candidate(cand(16'hFFFF, 16'h8000, 1'b1, 3'd0));

		// Raised target lets an already filled cell take one more entry.
		settle();
		load_setup(16'hFFFF, 16'hFFFF, 6'd63, 16'h8000, 16'd0, 6'd0, 16'd2, 2'd1);
		drive_candidate(cand(16'hFFFF, 16'h8000, 1'b0, 3'd0));
		drive_candidate(cand(16'hFFFF, 16'h8000, 1'b1, 3'd0));
		drive_candidate(cand(16'hFFFE, 16'h8000, 1'b1, 3'd0));
		drive_candidate(cand(16'hFFFF, 16'h8001, 1'b1, 3'd0));

		// Lowered target: a cell above it counts as full.
		settle();
		load_setup(16'd0, 16'd0, 6'd63, 16'h7FFF, 16'hFFFF, 6'd1, 16'd0, 2'd2);
		drive_candidate(cand(16'd31, 16'h7FFF, 1'b1, 3'd1));
		drive_candidate(cand(16'd31, 16'h7FFF, 1'b0, 3'd1));
		drive_candidate(cand(16'd32, 16'h7FFF, 1'b0, 3'd1));
		drive_candidate(cand(16'd31, 16'h7FFF, 1'b0, 3'd1));
		drive_candidate(cand(16'd5, 16'h7FFF, 1'b0, 3'd2));
		drive_candidate(cand(16'd5, 16'h7FFE, 1'b0, 3'd2));
		drive_candidate(cand(16'd0, 16'h7FFF, 1'b0, 3'd0));

		span = 2;
		while (sent < ITEM_BUDGET) begin
			settle();
			if (last_all_done)
				span = (span * 2 > 32) ? 32 : span * 2;

			r = $urandom_range(99);
			if (r < 5)
				pn = 6'd0;
			else if (r < 10)
				pn = 6'd63;
			else
				pn = 6'($urandom_range((span + 1) / 2, span));
			r = $urandom_range(99);
			if (r < 5)
				en = 6'd0;
			else if (r < 10)
				en = 6'd63;
			else
				en = 6'($urandom_range((span + 1) / 2, span));
			pe = grid_bins(pn);
			ee = grid_bins(en);

			if ($urandom_range(99) < 10)
				po = 16'(65535 - $urandom_range(0, 255));
			else
				po = 16'($urandom_range(0, 40000));
			r = $urandom_range(99);
			if (r < 5)
				pw = 16'd0;
			else if (r < 10)
				pw = 16'hFFFF;
			else
				pw = 16'($urandom_range(1, ((65535 - int'(po)) / pe > 1) ?
					(65535 - int'(po)) / pe : 1));

			if ($urandom_range(99) < 10)
				eo = 16'($urandom_range(0, 65535));
			else
				eo = 16'(-int'($urandom_range(0, 20000)));
			eo_int = int'($signed(eo));
			r = $urandom_range(99);
			if (r < 5)
				ew = 16'd0;
			else if (r < 10)
				ew = 16'hFFFF;
			else
				ew = 16'($urandom_range(1, ((32767 - eo_int) / ee > 1) ?
					(32767 - eo_int) / ee : 1));

			r = $urandom_range(99);
			if (r < 5)
				tg = 16'd0;
			else if (r < 9)
				tg = 16'hFFFF;
			else if (r < 13)
				tg = 16'($urandom_range(4, 65534));
			else
				tg = 16'($urandom_range(1, 3));

			r = $urandom_range(99);
			if (r < 70)
				pm = 2'd0;
			else if (r < 82)
				pm = 2'd1;
			else if (r < 94)
				pm = 2'd2;
			else
				pm = 2'd3;

			load_setup(po, pw, pn, eo, ew, en, tg, pm);
			pwe = (pw == '0) ? 1 : int'(pw);
			ewe = (ew == '0) ? 1 : int'(ew);
			phase_len = (pm == 2'd3) ? $urandom_range(5, 15) : $urandom_range(40, 120);

			for (int k = 0; k < phase_len && sent < ITEM_BUDGET; k++) begin
				quiet = (sent >= 600) && (sent < 900);
				pt_int = int'(po) + $urandom_range(0, pe - 1) * pwe + $urandom_range(0, pwe - 1);
				eta_int = eo_int + $urandom_range(0, ee - 1) * ewe + $urandom_range(0, ewe - 1);
				it.pt_value = 16'(pt_int);
				it.eta_value = 16'(eta_int);
				it.class_index = 3'($urandom_range(0, 3));
				if (pm == 2'd1)
					it.event_odd = 1'b1;
				else if (pm == 2'd2)
					it.event_odd = 1'b0;
				else
					it.event_odd = 1'($urandom_range(0, 1));

				r = $urandom_range(99);
				if (r >= 85) begin
					r = $urandom_range(3);
					if (r == 0) begin
						it.class_index = 3'($urandom_range(4, 7));
					end else if (r == 1) begin
						it.event_odd = ~it.event_odd;
					end else if (r == 2) begin
						it.pt_value = 16'($urandom_range(0, 65535));
						it.eta_value = 16'($urandom_range(0, 65535));
					end else begin
						if ($urandom_range(1))
							it.pt_value = po - 16'd1;
						else
							it.pt_value = 16'(int'(po) + pe * pwe);
						if ($urandom_range(1))
							it.eta_value = 16'(eo_int + ee * ewe);
					end
				end
				drive_candidate(it);
			end
		end

		settle();
		repeat (60) @(negedge clk);
		if (mismatches == 0 && pending == 0)
			$display("[ OK ] regression clean");
		else
			$display("[FAIL] regression broken");
		$finish;
	end

endmodule

FILE: binned_quota_sample_filter.f
hw/rtl/bqsf_pkg.sv
hw/rtl/bqsf_ram.sv
hw/rtl/bqsf_div.sv
hw/rtl/bqsf_dp.sv
hw/rtl/bqsf_ctrl.sv
hw/rtl/binned_quota_sample_filter.sv
hw/rtl/bqsf_checker.sv
tb/sv/bqsf_quota_checker.sv
tb/sv/tb_binned_quota_sample_filter.sv
